// ===== src/assert_macros.svh =====
// assertion macros used by the top level rtl file
// no dependencies; expects a clock named aclk and reset aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define CHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define CHC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/chc_pkg.sv =====
// types, codes and constants of the cons heap copying collector
// used by the controller, the datapath and the top level
package chc_pkg;

    localparam int HEAP_WORDS = 4096;
    localparam int IDX_W      = 12;
    localparam int ADDR_W     = IDX_W + 1;     // space bit on top of the index
    localparam int FREE_W     = 13;
    localparam int MAX_ROOTS  = 64;
    localparam int RC_W       = 7;
    localparam int SS_W       = 6;
    localparam int WORD_W     = 32;
    localparam int MIN_FREE   = 2;
    localparam int IN_W       = 80;
    localparam int OUT_W      = 48;

    localparam logic [1:0] TAG_PAIR = 2'd1;
    localparam logic [1:0] TAG_BH   = 2'd2;
    localparam logic [WORD_W-1:0] BROKEN_HEART = 32'h8000_0000;
    localparam logic [WORD_W-1:0] PAIR_BASE    = 32'h4000_0000;

    localparam logic [3:0] ACT_CONS     = 4'd0;
    localparam logic [3:0] ACT_READ_CAR = 4'd1;
    localparam logic [3:0] ACT_READ_CDR = 4'd2;
    localparam logic [3:0] ACT_SET_CAR  = 4'd3;
    localparam logic [3:0] ACT_SET_CDR  = 4'd4;
    localparam logic [3:0] ACT_GET_ROOT = 4'd5;
    localparam logic [3:0] ACT_SET_ROOT = 4'd6;
    localparam logic [3:0] ACT_COLLECT  = 4'd7;
    localparam logic [3:0] ACT_PUSH     = 4'd8;
    localparam logic [3:0] ACT_POP      = 4'd9;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_PAIR = 2'd1;
    localparam logic [1:0] ST_EXH  = 2'd2;
    localparam logic [1:0] ST_ROOT = 2'd3;

    localparam logic [2:0] REG_ROOT_COUNT = 3'd0;
    localparam logic [2:0] REG_STACK_SLOT = 3'd4;

    typedef enum logic [5:0] {
        CMD_NOP, CMD_CLEAR, CMD_LOAD, CMD_OUT,
        CMD_RD_A, CMD_RES_CAR, CMD_RES_CDR, CMD_WR_CAR_A, CMD_WR_CDR_A,
        CMD_RD_RI, CMD_RD_SS, CMD_WR_ROOT_B,
        CMD_ST_PAIR, CMD_ST_ROOT, CMD_ST_GC,
        CMD_A_RDCAR, CMD_B_RDCAR, CMD_ALLOC, CMD_WR_SS_RES,
        CMD_POP_V, CMD_POP_NX,
        CMD_GC_INIT, CMD_GC_RD_ROOT, CMD_GC_WR_ROOT, CMD_GC_SETFREE, CMD_GC_FLIP,
        CMD_W_A, CMD_W_B, CMD_A_W, CMD_B_W,
        CMD_RL_RD, CMD_RL_CHK, CMD_RL_FWD,
        CMD_SC_RD, CMD_W_RDCAR, CMD_W_RDCDR, CMD_SC_WCAR, CMD_SC_WCDR, CMD_SC_INC
    } cmd_op_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_RDRES, S_ROOTRES,
        S_PUSH1, S_PUSH2, S_PUSH3, S_PUSH_WR, S_ALLOC,
        S_POP1, S_POP2, S_POP3, S_POP4,
        S_GC_INIT, S_GC_ROOT, S_GC_ROOTW, S_GC_SETFREE, S_GC_PA, S_GC_PB,
        S_RL_START, S_RL_CHK, S_RL_FWD, S_RL_END,
        S_SC_LOOP, S_SC_CARW, S_SC_CDR, S_SC_CDRW, S_SC_NEXT,
        S_GC_FLIP, S_GC_ST, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RET_PCAR, RET_PCDR, RET_SCAR, RET_SCDR
    } ret_t;

    typedef struct packed {
        cmd_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic [3:0] act;
        logic       a_valid;
        logic       w_valid;
        logic       rd_bh;
        logic       free_full;
        logic       need_gc;
        logic       scan_lt_r;
        logic       scan_live;
        logic       ri_ok;
        logic       ss_ok;
        logic       clr_last;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== src/cons_heap_copying_collector.sv =====
// cons heap with cheney copying collector: one operation per input transfer, one result each
// cons and push may first run a collection, and so may the collect action: it copies the root
// slots and then scans each copied slot; a single read address serves both car and cdr memories
// in both semispaces. the next transfer is taken after the result is registered. reset clears
// control state and then sweeps all 8192 words of both semispaces, during which s_tready stays
// low
`include "assert_macros.svh"

module cons_heap_copying_collector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // action[3:0] object_a[35:4] object_b[67:36] root_index[73:68]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_object[31:0] status[33:32] free_words[46:34]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import chc_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t dp_st;

    assign pready = 1'b1;

    chc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dp_st    (dp_st),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    chc_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .dp_st    (dp_st),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

    `CHC_ASSERT(a_one_item, (s_tvalid && s_tready) |=> !s_tready, "second transfer taken mid operation")
    `CHC_ASSERT(a_free_range, m_tvalid |-> (m_tdata[46:34] <= 13'(HEAP_WORDS)), "free words out of range")
    `CHC_ASSERT(a_err_zero, (m_tvalid && (m_tdata[33:32] == ST_PAIR || m_tdata[33:32] == ST_ROOT)) |-> (m_tdata[31:0] == '0), "nonzero result on operand error")
    `CHC_ASSERT_ALWAYS(a_rst_idle, !aresetn |=> (!m_tvalid && !s_tready), "not quiet after reset")

endmodule

// ===== src/chc_ctrl.sv =====
// sequencer of the collector: one micro command per cycle to the datapath
// depends on chc_pkg
module chc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  chc_pkg::dp_status_t dp_st,
    input  logic                s_tvalid,
    output logic                s_tready,
    output chc_pkg::ctl_cmd_t   cmd
);
    import chc_pkg::*;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ret_reg   <= RET_PCAR;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = CMD_NOP;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = CMD_CLEAR;
                if (dp_st.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_DONE;
                unique case (dp_st.act)
                    ACT_CONS: state_next = dp_st.need_gc ? S_GC_INIT : S_ALLOC;
                    ACT_READ_CAR, ACT_READ_CDR: begin
                        if (!dp_st.a_valid) cmd.op = CMD_ST_PAIR;
                        else begin
                            cmd.op     = CMD_RD_A;
                            state_next = S_RDRES;
                        end
                    end
                    ACT_SET_CAR: cmd.op = dp_st.a_valid ? CMD_WR_CAR_A : CMD_ST_PAIR;
                    ACT_SET_CDR: cmd.op = dp_st.a_valid ? CMD_WR_CDR_A : CMD_ST_PAIR;
                    ACT_GET_ROOT: begin
                        if (!dp_st.ri_ok) cmd.op = CMD_ST_ROOT;
                        else begin
                            cmd.op     = CMD_RD_RI;
                            state_next = S_ROOTRES;
                        end
                    end
                    ACT_SET_ROOT: cmd.op = dp_st.ri_ok ? CMD_WR_ROOT_B : CMD_ST_ROOT;
                    ACT_COLLECT: state_next = S_GC_INIT;
                    ACT_PUSH: begin
                        if (!(dp_st.ri_ok && dp_st.ss_ok)) cmd.op = CMD_ST_ROOT;
                        else begin
                            cmd.op     = CMD_RD_RI;
                            state_next = S_PUSH1;
                        end
                    end
                    ACT_POP: begin
                        if (!(dp_st.ri_ok && dp_st.ss_ok)) cmd.op = CMD_ST_ROOT;
                        else begin
                            cmd.op     = CMD_RD_SS;
                            state_next = S_POP1;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RDRES: begin
                cmd.op     = (dp_st.act == ACT_READ_CAR) ? CMD_RES_CAR : CMD_RES_CDR;
                state_next = S_DONE;
            end
            S_ROOTRES: begin
                cmd.op     = CMD_RES_CAR;
                state_next = S_DONE;
            end
            S_PUSH1: begin
                cmd.op     = CMD_A_RDCAR;
                state_next = S_PUSH2;
            end
            S_PUSH2: begin
                cmd.op     = CMD_RD_SS;
                state_next = S_PUSH3;
            end
            S_PUSH3: begin
                cmd.op     = CMD_B_RDCAR;
                state_next = dp_st.need_gc ? S_GC_INIT : S_ALLOC;
            end
            S_ALLOC: begin
                cmd.op     = CMD_ALLOC;
                state_next = (dp_st.act == ACT_PUSH) ? S_PUSH_WR : S_DONE;
            end
            S_PUSH_WR: begin
                cmd.op     = CMD_WR_SS_RES;
                state_next = S_DONE;
            end
            S_POP1: begin
                cmd.op     = CMD_A_RDCAR;
                state_next = S_POP2;
            end
            S_POP2: begin
                if (!dp_st.a_valid) begin
                    cmd.op     = CMD_ST_PAIR;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = CMD_RD_A;
                    state_next = S_POP3;
                end
            end
            S_POP3: begin
                cmd.op     = CMD_POP_V;
                state_next = S_POP4;
            end
            S_POP4: begin
                cmd.op     = CMD_POP_NX;
                state_next = S_DONE;
            end
            S_GC_INIT: begin
                cmd.op     = CMD_GC_INIT;
                state_next = S_GC_ROOT;
            end
            S_GC_ROOT: begin
                if (dp_st.scan_lt_r) begin
                    cmd.op     = CMD_GC_RD_ROOT;
                    state_next = S_GC_ROOTW;
                end else begin
                    state_next = S_GC_SETFREE;
                end
            end
            S_GC_ROOTW: begin
                cmd.op     = CMD_GC_WR_ROOT;
                state_next = S_GC_ROOT;
            end
            S_GC_SETFREE: begin
                cmd.op     = CMD_GC_SETFREE;
                state_next = (dp_st.act == ACT_COLLECT) ? S_SC_LOOP : S_GC_PA;
            end
            S_GC_PA: begin
                cmd.op     = CMD_W_A;
                ret_next   = RET_PCAR;
                state_next = S_RL_START;
            end
            S_GC_PB: begin
                cmd.op     = CMD_W_B;
                ret_next   = RET_PCDR;
                state_next = S_RL_START;
            end
            // relocation of the word register, shared by all callers
            S_RL_START: begin
                if (dp_st.w_valid) begin
                    cmd.op     = CMD_RL_RD;
                    state_next = S_RL_CHK;
                end else begin
                    state_next = S_RL_END;
                end
            end
            S_RL_CHK: begin
                cmd.op     = CMD_RL_CHK;
                state_next = (dp_st.rd_bh || dp_st.free_full) ? S_RL_END : S_RL_FWD;
            end
            S_RL_FWD: begin
                cmd.op     = CMD_RL_FWD;
                state_next = S_RL_END;
            end
            S_RL_END: begin
                unique case (ret_reg)
                    RET_PCAR: begin
                        cmd.op     = CMD_A_W;
                        state_next = S_GC_PB;
                    end
                    RET_PCDR: begin
                        cmd.op     = CMD_B_W;
                        state_next = S_SC_LOOP;
                    end
                    RET_SCAR: begin
                        cmd.op     = CMD_SC_WCAR;
                        state_next = S_SC_CDR;
                    end
                    RET_SCDR: begin
                        cmd.op     = CMD_SC_WCDR;
                        state_next = S_SC_NEXT;
                    end
                endcase
            end
            S_SC_LOOP: begin
                if (dp_st.scan_live) begin
                    cmd.op     = CMD_SC_RD;
                    state_next = S_SC_CARW;
                end else begin
                    state_next = S_GC_FLIP;
                end
            end
            S_SC_CARW: begin
                cmd.op     = CMD_W_RDCAR;
                ret_next   = RET_SCAR;
                state_next = S_RL_START;
            end
            S_SC_CDR: begin
                // root slots carry no live cdr
                if (!dp_st.scan_lt_r) begin
                    cmd.op     = CMD_SC_RD;
                    state_next = S_SC_CDRW;
                end else begin
                    state_next = S_SC_NEXT;
                end
            end
            S_SC_CDRW: begin
                cmd.op     = CMD_W_RDCDR;
                ret_next   = RET_SCDR;
                state_next = S_RL_START;
            end
            S_SC_NEXT: begin
                cmd.op     = CMD_SC_INC;
                state_next = S_SC_LOOP;
            end
            S_GC_FLIP: begin
                cmd.op     = CMD_GC_FLIP;
                state_next = (dp_st.act == ACT_COLLECT) ? S_GC_ST : S_ALLOC;
            end
            S_GC_ST: begin
                cmd.op     = CMD_ST_GC;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (dp_st.out_free) begin
                    cmd.op     = CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== src/chc_datapath.sv =====
// heap memories, pointers, operand registers, config registers, output register
// depends on chc_pkg; driven by chc_ctrl commands
module chc_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  chc_pkg::ctl_cmd_t                cmd,
    output chc_pkg::dp_status_t              dp_st,
    input  logic [chc_pkg::IN_W-1:0]         s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [chc_pkg::OUT_W-1:0]        m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata
);
    import chc_pkg::*;

    localparam int MEM_DEPTH = 2 * HEAP_WORDS;

    logic [WORD_W-1:0] car_mem [MEM_DEPTH];
    logic [WORD_W-1:0] cdr_mem [MEM_DEPTH];

    logic [3:0]        act_reg, act_next;
    logic [WORD_W-1:0] a_reg, a_next, b_reg, b_next, w_reg, w_next, res_reg, res_next;
    logic [SS_W-1:0]   ri_reg, ri_next;
    logic [1:0]        st_reg, st_next;
    logic              ovf_reg, ovf_next;
    logic              sp_reg, sp_next;
    logic [FREE_W-1:0] free_reg, free_next, scan_reg, scan_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [RC_W-1:0]   rc_reg, rc_next;
    logic [SS_W-1:0]   ss_reg, ss_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic [WORD_W-1:0] rd_car, rd_cdr;
    logic [ADDR_W-1:0] rd_addr, car_waddr, cdr_waddr;
    logic [WORD_W-1:0] car_wdata, cdr_wdata;
    logic              car_we, cdr_we;

    logic [RC_W-1:0]   roots;
    logic [RC_W-1:0]   wr_roots;
    logic [FREE_W-1:0] roots_ext;
    logic [FREE_W-1:0] free_words;
    logic [WORD_W-1:0] free_pair;
    logic              cfg_wr;

    function automatic logic pair_ok(input logic [WORD_W-1:0] w);
        return (w[31:30] == TAG_PAIR) && (w[29:IDX_W] == '0);
    endfunction

    function automatic logic [RC_W-1:0] clamp_roots(input logic [RC_W-1:0] v);
        return (v > RC_W'(MAX_ROOTS)) ? RC_W'(MAX_ROOTS) : v;
    endfunction

    assign roots      = clamp_roots(rc_reg);
    assign roots_ext  = FREE_W'(roots);
    assign free_words = FREE_W'(HEAP_WORDS) - free_reg;
    assign free_pair  = PAIR_BASE | WORD_W'(free_reg);
    assign cfg_wr     = psel && penable && pwrite;
    assign wr_roots   = clamp_roots(pwdata[RC_W-1:0]);

    assign dp_st.act       = act_reg;
    assign dp_st.a_valid   = pair_ok(a_reg);
    assign dp_st.w_valid   = pair_ok(w_reg);
    assign dp_st.rd_bh     = (rd_car[31:30] == TAG_BH);
    assign dp_st.free_full = (free_reg >= FREE_W'(HEAP_WORDS));
    assign dp_st.need_gc   = ((14'(free_reg) + 14'(MIN_FREE)) > 14'(HEAP_WORDS));
    assign dp_st.scan_lt_r = (scan_reg < roots_ext);
    assign dp_st.scan_live = (scan_reg < free_reg) && (scan_reg < FREE_W'(HEAP_WORDS));
    assign dp_st.ri_ok     = (RC_W'(ri_reg) < roots);
    assign dp_st.ss_ok     = (RC_W'(ss_reg) < roots);
    assign dp_st.clr_last  = (clr_reg == '1);
    assign dp_st.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        unique case (paddr)
            REG_ROOT_COUNT: prdata = 32'(rc_reg);
            REG_STACK_SLOT: prdata = 32'(ss_reg);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        act_next     = act_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        w_next       = w_reg;
        res_next     = res_reg;
        ri_next      = ri_reg;
        st_next      = st_reg;
        ovf_next     = ovf_reg;
        sp_next      = sp_reg;
        free_next    = free_reg;
        scan_next    = scan_reg;
        clr_next     = clr_reg;
        rc_next      = rc_reg;
        ss_next      = ss_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rd_addr      = {sp_reg, a_reg[IDX_W-1:0]};
        car_we       = 1'b0;
        cdr_we       = 1'b0;
        car_waddr    = {sp_reg, a_reg[IDX_W-1:0]};
        cdr_waddr    = {sp_reg, a_reg[IDX_W-1:0]};
        car_wdata    = b_reg;
        cdr_wdata    = b_reg;

        unique case (cmd.op)
            CMD_NOP: ;
            CMD_CLEAR: begin
                car_we    = 1'b1;
                cdr_we    = 1'b1;
                car_waddr = clr_reg;
                cdr_waddr = clr_reg;
                car_wdata = '0;
                cdr_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
            end
            CMD_LOAD: begin
                act_next = s_tdata[3:0];
                a_next   = s_tdata[35:4];
                b_next   = s_tdata[67:36];
                ri_next  = s_tdata[73:68];
                res_next = '0;
                st_next  = ST_OK;
                ovf_next = 1'b0;
            end
            CMD_OUT: begin
                m_valid_next = 1'b1;
                m_data_next  = {1'b0, free_words, st_reg, res_reg};
            end
            CMD_RD_A:     rd_addr = {sp_reg, a_reg[IDX_W-1:0]};
            CMD_RES_CAR:  res_next = rd_car;
            CMD_RES_CDR:  res_next = rd_cdr;
            CMD_WR_CAR_A: car_we = 1'b1;
            CMD_WR_CDR_A: cdr_we = 1'b1;
            CMD_RD_RI:    rd_addr = {sp_reg, IDX_W'(ri_reg)};
            CMD_RD_SS:    rd_addr = {sp_reg, IDX_W'(ss_reg)};
            CMD_WR_ROOT_B: begin
                car_we    = 1'b1;
                car_waddr = {sp_reg, IDX_W'(ri_reg)};
            end
            CMD_ST_PAIR: begin
                st_next  = ST_PAIR;
                res_next = '0;
            end
            CMD_ST_ROOT: begin
                st_next  = ST_ROOT;
                res_next = '0;
            end
            CMD_ST_GC: st_next = (ovf_reg || dp_st.free_full) ? ST_EXH : ST_OK;
            CMD_A_RDCAR: a_next = rd_car;
            CMD_B_RDCAR: b_next = rd_car;
            CMD_ALLOC: begin
                if (dp_st.free_full) begin
                    res_next = '0;
                    st_next  = ST_EXH;
                end else begin
                    car_we    = 1'b1;
                    cdr_we    = 1'b1;
                    car_waddr = {sp_reg, free_reg[IDX_W-1:0]};
                    cdr_waddr = {sp_reg, free_reg[IDX_W-1:0]};
                    car_wdata = a_reg;
                    cdr_wdata = b_reg;
                    res_next  = free_pair;
                    free_next = free_reg + FREE_W'(1);
                    st_next   = ovf_reg ? ST_EXH : ST_OK;
                end
            end
            CMD_WR_SS_RES: begin
                car_we    = (res_reg != '0);
                car_waddr = {sp_reg, IDX_W'(ss_reg)};
                car_wdata = res_reg;
            end
            CMD_POP_V: begin
                res_next  = rd_car;
                b_next    = rd_cdr;
                car_we    = 1'b1;
                car_waddr = {sp_reg, IDX_W'(ri_reg)};
                car_wdata = rd_car;
            end
            // written after the value so a pop onto the stack slot keeps the cdr
            CMD_POP_NX: begin
                car_we    = 1'b1;
                car_waddr = {sp_reg, IDX_W'(ss_reg)};
                car_wdata = b_reg;
            end
            CMD_GC_INIT:    scan_next = '0;
            CMD_GC_RD_ROOT: rd_addr = {sp_reg, scan_reg[IDX_W-1:0]};
            CMD_GC_WR_ROOT: begin
                car_we    = 1'b1;
                cdr_we    = 1'b1;
                car_waddr = {~sp_reg, scan_reg[IDX_W-1:0]};
                cdr_waddr = {~sp_reg, scan_reg[IDX_W-1:0]};
                car_wdata = rd_car;
                cdr_wdata = '0;
                scan_next = scan_reg + FREE_W'(1);
            end
            CMD_GC_SETFREE: begin
                free_next = roots_ext;
                scan_next = '0;
            end
            CMD_GC_FLIP: sp_next = ~sp_reg;
            CMD_W_A:     w_next = a_reg;
            CMD_W_B:     w_next = b_reg;
            CMD_A_W:     a_next = w_reg;
            CMD_B_W:     b_next = w_reg;
            CMD_RL_RD:   rd_addr = {sp_reg, w_reg[IDX_W-1:0]};
            CMD_RL_CHK: begin
                if (dp_st.rd_bh) begin
                    w_next = rd_cdr;
                end else if (dp_st.free_full) begin
                    ovf_next = 1'b1;
                    w_next   = '0;
                end else begin
                    car_we    = 1'b1;
                    cdr_we    = 1'b1;
                    car_waddr = {~sp_reg, free_reg[IDX_W-1:0]};
                    cdr_waddr = {~sp_reg, free_reg[IDX_W-1:0]};
                    car_wdata = rd_car;
                    cdr_wdata = rd_cdr;
                end
            end
            CMD_RL_FWD: begin
                car_we    = 1'b1;
                cdr_we    = 1'b1;
                car_waddr = {sp_reg, w_reg[IDX_W-1:0]};
                cdr_waddr = {sp_reg, w_reg[IDX_W-1:0]};
                car_wdata = BROKEN_HEART;
                cdr_wdata = free_pair;
                w_next    = free_pair;
                free_next = free_reg + FREE_W'(1);
            end
            CMD_SC_RD:   rd_addr = {~sp_reg, scan_reg[IDX_W-1:0]};
            CMD_W_RDCAR: w_next = rd_car;
            CMD_W_RDCDR: w_next = rd_cdr;
            CMD_SC_WCAR: begin
                car_we    = 1'b1;
                car_waddr = {~sp_reg, scan_reg[IDX_W-1:0]};
                car_wdata = w_reg;
            end
            CMD_SC_WCDR: begin
                cdr_we    = 1'b1;
                cdr_waddr = {~sp_reg, scan_reg[IDX_W-1:0]};
                cdr_wdata = w_reg;
            end
            CMD_SC_INC: scan_next = scan_reg + FREE_W'(1);
            default: ;
        endcase

        // the user must send config transfers only while no operation is in flight; the block does not enforce it
        if (cfg_wr && paddr == REG_ROOT_COUNT) begin
            rc_next = pwdata[RC_W-1:0];
            if (free_reg < FREE_W'(wr_roots)) free_next = FREE_W'(wr_roots);
        end
        if (cfg_wr && paddr == REG_STACK_SLOT) ss_next = pwdata[SS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (car_we) car_mem[car_waddr] <= car_wdata;
        if (cdr_we) cdr_mem[cdr_waddr] <= cdr_wdata;
        rd_car <= car_mem[rd_addr];
        rd_cdr <= cdr_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= 1'b0;
            free_reg    <= '0;
            scan_reg    <= '0;
            clr_reg     <= '0;
            rc_reg      <= '0;
            ss_reg      <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sp_reg      <= sp_next;
            free_reg    <= free_next;
            scan_reg    <= scan_next;
            clr_reg     <= clr_next;
            rc_reg      <= rc_next;
            ss_reg      <= ss_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        w_reg      <= w_next;
        res_reg    <= res_next;
        ri_reg     <= ri_next;
        st_reg     <= st_next;
        m_data_reg <= m_data_next;
    end

endmodule
